// ===== hdl/plz_pkg.sv =====
// plz_pkg: types, constants and control structs shared by the palette/lz line decoder
// used by the channel interfaces' users, the controller, the datapath and the top level
package plz_pkg;

    localparam int PAL_ENTRIES_DEF = 4096;
    localparam int HIST_PIXELS_DEF = 512;

    localparam logic [15:0] COPY_FLAG  = 16'h8000;
    localparam logic [5:0]  LEN_MASK   = 6'h3F;
    localparam logic [12:0] COUNT_MASK = 13'h1FFF;
    localparam logic [15:0] RUN_BIT    = 16'h4000;
    localparam logic [15:0] BYTE_BIT   = 16'h2000;
    localparam logic [7:0]  SUBOP_COPY = 8'h80;
    localparam logic [10:0] DIST_BASE  = 11'd1024;

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_B_RUNIDX = 3'd1,
        PH_B_SUBOP  = 3'd2,
        PH_B_LIST   = 3'd3,
        PH_B_BACKLO = 3'd4,
        PH_W_OPHI   = 3'd5,
        PH_W_IDX    = 3'd6,
        PH_W_IDXHI  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_COPY  = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'd0,
        ST_IDLE   = 4'd1,
        ST_READ   = 4'd2,
        ST_PIXEL  = 4'd3,
        ST_PUSH   = 4'd4,
        ST_CRD_A  = 4'd5,
        ST_CWR_A  = 4'd6,
        ST_CRD_B  = 4'd7,
        ST_CWR_B  = 4'd8,
        ST_EMIT   = 4'd9
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic pal_rd;
        logic px_emit;
        logic push;
        logic cp_rd;
        logic cp_wr_a;
        logic cp_wr_b;
        logic cp_emit;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic clr_last;
        logic push_single;
        logic push_last;
        logic rem_one;
        logic rem_zero;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/plz_ifs.sv =====
// plz_ifs: valid/ready channel interfaces for configuration, input items and results
// no dependencies
interface plz_cfg_if;
    logic valid;
    logic ready;
    logic code_format;
    modport source (output valid, output code_format, input ready);
    modport sink (input valid, input code_format, output ready);
endinterface

interface plz_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  data_byte;
    logic        line_end;
    logic [15:0] palette_index;
    logic [23:0] palette_color;
    modport source (output valid, output command, output data_byte, output line_end,
                    output palette_index, output palette_color, input ready);
    modport sink (input valid, input command, input data_byte, input line_end,
                  input palette_index, input palette_color, output ready);
endinterface

interface plz_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] first_pixel;
    logic [23:0] second_pixel;
    logic        pair_valid;
    logic [12:0] repeat_count;
    logic        index_error;
    logic        last;
    modport source (output valid, output first_pixel, output second_pixel, output pair_valid,
                    output repeat_count, output index_error, output last, input ready);
    modport sink (input valid, input first_pixel, input second_pixel, input pair_valid,
                  input repeat_count, input index_error, input last, output ready);
endinterface

// ===== hdl/palette_lz_line_decoder.sv =====
// palette_lz_line_decoder: top level, controller plus datapath
// depends on plz_pkg, plz_ifs, plz_ctrl and plz_dp
// palette write: stored as it is accepted; literal index or run: palette read in ST_READ, result
//   loaded in ST_PIXEL, then a run writes min(count, HISTORY_PIXELS) - 1 more history entries
// copy: a read and a write per pixel through the single history read port, then ST_EMIT per result
// one item at a time; configuration writes accepted every cycle
// reset: asynchronous, then a clearing pass zeroes the history
module palette_lz_line_decoder
    import plz_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF,
    parameter int HISTORY_PIXELS  = HIST_PIXELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    plz_cfg_if.sink   cfg,
    plz_in_if.sink    stream,
    plz_out_if.source pixels
);

    cmd_t    cmd;
    status_t st;

    plz_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .st       (st),
        .cmd      (cmd)
    );

    plz_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .HISTORY_PIXELS  (HISTORY_PIXELS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .stream (stream),
        .pixels (pixels),
        .cmd    (cmd),
        .st     (st)
    );

endmodule

// ===== hdl/plz_ctrl.sv =====
// plz_ctrl: sequencing state machine of the decoder
// depends on plz_pkg; drives the datapath through cmd_t and watches status_t
module plz_ctrl
    import plz_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    case (st.act)
                        ACT_PIXEL: state_next = ST_READ;
                        ACT_COPY:  state_next = ST_CRD_A;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.pal_rd = 1'b1;
                state_next = ST_PIXEL;
            end
            ST_PIXEL:
            begin
                if (st.out_free)
                begin
                    cmd.px_emit = 1'b1;
                    state_next = st.push_single ? ST_IDLE : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // remaining history fill of a run
                cmd.push = 1'b1;
                if (st.push_last)
                    state_next = ST_IDLE;
            end
            ST_CRD_A:
            begin
                cmd.cp_rd = 1'b1;
                state_next = ST_CWR_A;
            end
            ST_CWR_A:
            begin
                cmd.cp_wr_a = 1'b1;
                state_next = st.rem_one ? ST_EMIT : ST_CRD_B;
            end
            ST_CRD_B:
            begin
                cmd.cp_rd = 1'b1;
                state_next = ST_CWR_B;
            end
            ST_CWR_B:
            begin
                cmd.cp_wr_b = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.cp_emit = 1'b1;
                    state_next = st.rem_zero ? ST_IDLE : ST_CRD_A;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/plz_dp.sv =====
// plz_dp: parser registers, palette and history memories, copy counters, result register
// depends on plz_pkg and plz_ifs; commanded by plz_ctrl
module plz_dp
    import plz_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF,
    parameter int HISTORY_PIXELS  = HIST_PIXELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    plz_cfg_if.sink   cfg,
    plz_in_if.sink    stream,
    plz_out_if.source pixels,
    input  cmd_t      cmd,
    output status_t   st
);

    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam int HW = $clog2(HISTORY_PIXELS);
    localparam int CW = $clog2(HISTORY_PIXELS + 1);

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [12:0] pend_reg, pend_next;
    logic        bim_reg, bim_next;
    logic        run_reg, run_next;
    logic        fmt_reg;

    // decoded action of the current item
    act_t        act;
    logic [15:0] d_idx;
    logic [12:0] d_cnt;
    logic [15:0] d_word;
    logic [6:0]  d_n;
    logic [15:0] w_le, w_be;
    logic [12:0] pend_dec;

    // action registers
    logic [15:0] a_idx_reg;
    logic [12:0] a_cnt_reg;
    logic [9:0]  a_dist_reg;
    logic [6:0]  rem_reg;
    logic [CW-1:0] push_cnt_reg;
    logic [CW-1:0] lim;
    logic        a_err;
    logic [23:0] px;
    logic        acc;

    // memories
    logic [23:0] palette_mem [PALETTE_ENTRIES];
    logic [23:0] hist_mem [HISTORY_PIXELS];
    logic [23:0] pal_rdata_reg;
    logic [23:0] hist_rdata_reg;
    logic [HW-1:0] ptr_reg;
    logic [HW-1:0] rd_addr;
    logic [HW:0]   ptr_ext, dist_ext;
    logic        hist_we;
    logic [23:0] hist_wdata;
    logic        pal_we;

    // copy pair staging
    logic [23:0] pix_a_reg, pix_b_reg;
    logic        pair_reg;

    // result register
    logic        out_valid_reg;
    logic [23:0] out_first_reg, out_second_reg;
    logic        out_pair_reg, out_err_reg, out_last_reg;
    logic [12:0] out_rep_reg;

    assign acc = cmd.in_ready && stream.valid;
    assign stream.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= 1'b0;
        else if (cfg.valid)
            fmt_reg <= cfg.code_format;
    end

    assign w_le = {stream.data_byte, held_reg};
    assign w_be = {held_reg, stream.data_byte};
    assign pend_dec = pend_reg - 13'd1;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        bim_next   = bim_reg;
        run_next   = run_reg;
        act    = ACT_NONE;
        d_idx  = {8'd0, stream.data_byte};
        d_cnt  = 13'd1;
        d_word = w_be;
        d_n    = 7'd0;
        if (!stream.command)
        begin
            case (phase_reg)
                PH_OPCODE:
                begin
                    if (fmt_reg)
                    begin
                        held_next  = stream.data_byte;
                        phase_next = PH_W_OPHI;
                    end
                    else if (stream.data_byte != 8'd0)
                    begin
                        pend_next  = {5'd0, stream.data_byte};
                        phase_next = PH_B_RUNIDX;
                    end
                    else
                        phase_next = PH_B_SUBOP;
                end
                PH_B_RUNIDX:
                begin
                    act        = (pend_reg != 13'd0) ? ACT_PIXEL : ACT_NONE;
                    d_cnt      = pend_reg;
                    pend_next  = 13'd0;
                    phase_next = PH_OPCODE;
                end
                PH_B_SUBOP:
                begin
                    if (stream.data_byte < SUBOP_COPY)
                    begin
                        pend_next  = {5'd0, stream.data_byte} + 13'd2;
                        phase_next = PH_B_LIST;
                    end
                    else
                    begin
                        held_next  = stream.data_byte;
                        phase_next = PH_B_BACKLO;
                    end
                end
                PH_B_LIST:
                begin
                    act        = ACT_PIXEL;
                    pend_next  = pend_dec;
                    phase_next = (pend_dec != 13'd0) ? PH_B_LIST : PH_OPCODE;
                end
                PH_B_BACKLO:
                begin
                    act        = ACT_COPY;
                    d_word     = w_be;
                    d_n        = {1'b0, w_be[5:0] & LEN_MASK} + 7'd4;
                    phase_next = PH_OPCODE;
                end
                PH_W_OPHI:
                begin
                    if ((w_le & COPY_FLAG) != 16'd0)
                    begin
                        act        = ACT_COPY;
                        d_word     = w_le;
                        d_n        = {1'b0, w_le[5:0] & LEN_MASK} + 7'd2;
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        pend_next = w_le[12:0] & COUNT_MASK;
                        bim_next  = (w_le & BYTE_BIT) != 16'd0;
                        run_next  = (w_le & RUN_BIT) != 16'd0;
                        if ((w_le & RUN_BIT) == 16'd0 && w_le[12:0] == 13'd0)
                            phase_next = PH_OPCODE;
                        else
                            phase_next = PH_W_IDX;
                    end
                end
                default:
                begin
                    // word-format index, byte wide or completed little-endian word
                    if (phase_reg == PH_W_IDX && !bim_reg)
                    begin
                        held_next  = stream.data_byte;
                        phase_next = PH_W_IDXHI;
                    end
                    else
                    begin
                        d_idx = (phase_reg == PH_W_IDX) ? {8'd0, stream.data_byte} : w_le;
                        if (run_reg)
                        begin
                            act        = (pend_reg != 13'd0) ? ACT_PIXEL : ACT_NONE;
                            d_cnt      = pend_reg;
                            pend_next  = 13'd0;
                            phase_next = PH_OPCODE;
                        end
                        else
                        begin
                            act        = ACT_PIXEL;
                            pend_next  = pend_dec;
                            phase_next = (pend_dec != 13'd0) ? PH_W_IDX : PH_OPCODE;
                        end
                    end
                end
            endcase
            if (stream.line_end)
            begin
                phase_next = PH_OPCODE;
                pend_next  = 13'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPCODE;
            held_reg  <= 8'd0;
            pend_reg  <= 13'd0;
            bim_reg   <= 1'b0;
            run_reg   <= 1'b0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            bim_reg   <= bim_next;
            run_reg   <= run_next;
        end
    end

    // action registers, loaded with every accepted item
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_idx_reg  <= d_idx;
            a_cnt_reg  <= d_cnt;
            a_dist_reg <= 10'(DIST_BASE - {1'b0, d_word[15:6]});
        end
    end

    assign a_err = {1'b0, a_idx_reg} >= 17'(PALETTE_ENTRIES);
    assign px = a_err ? 24'd0 : pal_rdata_reg;
    assign lim = ({19'd0, a_cnt_reg} < 32'(HISTORY_PIXELS)) ? CW'(a_cnt_reg)
                                                            : CW'(HISTORY_PIXELS);

    assign pal_we = acc && stream.command &&
                    ({1'b0, stream.palette_index} < 17'(PALETTE_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (pal_we)
            palette_mem[stream.palette_index[PW-1:0]] <= stream.palette_color;
        if (cmd.pal_rd)
            pal_rdata_reg <= palette_mem[a_idx_reg[PW-1:0]];
    end

    // history read address wraps below zero
    assign ptr_ext  = {1'b0, ptr_reg};
    assign dist_ext = (HW+1)'(a_dist_reg);
    always_comb
    begin
        if (ptr_ext >= dist_ext)
            rd_addr = HW'(ptr_ext - dist_ext);
        else
            rd_addr = HW'(ptr_ext + (HW+1)'(HISTORY_PIXELS) - dist_ext);
    end

    assign hist_we = cmd.clr_wr || cmd.px_emit || cmd.push || cmd.cp_wr_a || cmd.cp_wr_b;
    always_comb
    begin
        if (cmd.clr_wr)
            hist_wdata = 24'd0;
        else if (cmd.px_emit || cmd.push)
            hist_wdata = px;
        else
            hist_wdata = hist_rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[ptr_reg] <= hist_wdata;
        if (cmd.cp_rd)
            hist_rdata_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else if (hist_we)
            ptr_reg <= (ptr_reg == HW'(HISTORY_PIXELS - 1)) ? '0 : ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_cnt_reg <= '0;
            rem_reg      <= 7'd0;
            pair_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.px_emit)
                push_cnt_reg <= lim - 1'b1;
            else if (cmd.push)
                push_cnt_reg <= push_cnt_reg - 1'b1;
            if (acc)
                rem_reg <= d_n;
            else if (cmd.cp_wr_a || cmd.cp_wr_b)
                rem_reg <= rem_reg - 7'd1;
            if (cmd.cp_wr_a)
                pair_reg <= 1'b0;
            else if (cmd.cp_wr_b)
                pair_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cp_wr_a)
            pix_a_reg <= hist_rdata_reg;
        if (cmd.cp_wr_b)
            pix_b_reg <= hist_rdata_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.px_emit || cmd.cp_emit)
            out_valid_reg <= 1'b1;
        else if (pixels.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.px_emit)
        begin
            out_first_reg  <= px;
            out_second_reg <= 24'd0;
            out_pair_reg   <= 1'b0;
            out_rep_reg    <= a_cnt_reg;
            out_err_reg    <= a_err;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.cp_emit)
        begin
            out_first_reg  <= pix_a_reg;
            out_second_reg <= pair_reg ? pix_b_reg : 24'd0;
            out_pair_reg   <= pair_reg;
            out_rep_reg    <= 13'd1;
            out_err_reg    <= 1'b0;
            out_last_reg   <= rem_reg == 7'd0;
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.first_pixel  = out_first_reg;
    assign pixels.second_pixel = out_second_reg;
    assign pixels.pair_valid   = out_pair_reg;
    assign pixels.repeat_count = out_rep_reg;
    assign pixels.index_error  = out_err_reg;
    assign pixels.last         = out_last_reg;

    assign st.act         = acc ? act : ACT_NONE;
    assign st.clr_last    = ptr_reg == HW'(HISTORY_PIXELS - 1);
    assign st.push_single = lim == CW'(1);
    assign st.push_last   = push_cnt_reg == CW'(1);
    assign st.rem_one     = rem_reg == 7'd1;
    assign st.rem_zero    = rem_reg == 7'd0;
    assign st.out_free    = !out_valid_reg || pixels.ready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.px_emit || cmd.cp_emit) |-> (!out_valid_reg || pixels.ready))
        else $error("result register loaded while still held");

    a_pair_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pair_reg) |-> (out_rep_reg == 13'd1 && !out_err_reg))
        else $error("pixel pair with repeat count or error");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_first_reg == 24'd0))
        else $error("index error with nonzero pixel");

    a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |=> (ptr_reg != $past(ptr_reg)))
        else $error("history pointer did not advance on write");

endmodule

// ===== verif/plz_tb_ifs_note.sv =====
// plz_tb_ifs_note: intentionally minimal; the channel interfaces come from hdl/plz_ifs.sv
// depends on plz_pkg only for completeness of the compile order
package plz_tb_types;
    import plz_pkg::*;

    typedef struct packed {
        logic [23:0] first_pixel;
        logic [23:0] second_pixel;
        logic        pair_valid;
        logic [12:0] repeat_count;
        logic        index_error;
        logic        last;
    } pixel_result_t;
endpackage

// ===== verif/palette_lz_line_decoder_tb.sv =====
// palette_lz_line_decoder_tb: drives palette writes and compressed bytes in both code formats,
// predicts decoded pixels and compares each result item; depends on plz_pkg, plz_tb_types, plz_ifs, the rtl
module palette_lz_line_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import plz_pkg::*;
    import plz_tb_types::*;

    localparam int PAL_N  = 4096;
    localparam int HIST_N = 512;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plz_cfg_if cfg_ch();
    plz_in_if  in_ch();
    plz_out_if out_ch();

    palette_lz_line_decoder dut (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_ch.sink), .stream(in_ch.sink),
        .pixels(out_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [23:0]  pal_mem [PAL_N];
    bit           pal_written [PAL_N];
    logic [23:0]  hist_mem [HIST_N];
    logic [8:0]   hist_ptr;
    phase_t       phase;
    logic [7:0]   held;
    logic [12:0]  pend;
    logic         byte_idx;
    logic         run_md;
    logic         fmt;

    pixel_result_t pixel_queue[$];
    int errors = 0;
    int mismatches = 0;
    bit stall_long = 0;

    // ------------------------------------------------------------ predictor
    function automatic void hist_push(logic [23:0] px);
        hist_mem[hist_ptr] = px;
        hist_ptr = hist_ptr + 9'd1;
    endfunction

    function automatic void add_result(logic [23:0] a, logic [23:0] b, logic pv,
                                       logic [12:0] rep, logic err);
        pixel_result_t r;
        r.first_pixel = a;
        r.second_pixel = b;
        r.pair_valid = pv;
        r.repeat_count = rep;
        r.index_error = err;
        r.last = 1'b0;
        pixel_queue.push_back(r);
    endfunction

    function automatic logic [23:0] pal_read(logic [15:0] idx, output logic err);
        err = (idx >= PAL_N);
        return err ? 24'd0 : pal_mem[idx];
    endfunction

    function automatic void emit_run(logic [15:0] idx, logic [12:0] cnt);
        logic err;
        logic [23:0] px;
        int n;
        if (cnt == 0)
            return;
        px = pal_read(idx, err);
        n = (cnt < HIST_N) ? cnt : HIST_N;
        for (int i = 0; i < n; i++)
            hist_push(px);
        add_result(px, 24'd0, 1'b0, cnt, err);
    endfunction

    function automatic void emit_single(logic [15:0] idx);
        logic err;
        logic [23:0] px;
        px = pal_read(idx, err);
        hist_push(px);
        add_result(px, 24'd0, 1'b0, 13'd1, err);
    endfunction

    function automatic void emit_copy(logic [15:0] code, int n);
        logic [9:0] back_dist;
        logic [23:0] a, b;
        back_dist = 10'(DIST_BASE - 11'(code[15:6]));
        for (int i = 0; i < n; i += 2)
        begin
            a = hist_mem[9'(hist_ptr - back_dist)];
            hist_push(a);
            if (i + 1 < n)
            begin
                b = hist_mem[9'(hist_ptr - back_dist)];
                hist_push(b);
                add_result(a, b, 1'b1, 13'd1, 1'b0);
            end
            else
                add_result(a, 24'd0, 1'b0, 13'd1, 1'b0);
        end
    endfunction

    function automatic void word_index(logic [15:0] idx);
        if (run_md)
        begin
            emit_run(idx, pend);
            pend = 13'd0;
            phase = PH_OPCODE;
        end
        else
        begin
            emit_single(idx);
            pend = pend - 13'd1;
            phase = (pend != 0) ? PH_W_IDX : PH_OPCODE;
        end
    endfunction

    function automatic void predict_item(logic cmd, logic [7:0] by, logic lend,
                                         logic [15:0] pi, logic [23:0] col);
        int before_n;
        logic [15:0] c;
        before_n = pixel_queue.size();
        if (cmd)
        begin
            if (pi < PAL_N)
            begin
                pal_mem[pi] = col;
                pal_written[pi] = 1;
            end
            return;
        end
        case (phase)
            PH_OPCODE:
                if (fmt)
                begin
                    held = by;
                    phase = PH_W_OPHI;
                end
                else if (by != 0)
                begin
                    pend = {5'd0, by};
                    phase = PH_B_RUNIDX;
                end
                else
                    phase = PH_B_SUBOP;
            PH_B_RUNIDX:
            begin
                emit_run({8'd0, by}, pend);
                pend = 13'd0;
                phase = PH_OPCODE;
            end
            PH_B_SUBOP:
                if (by < SUBOP_COPY)
                begin
                    pend = {5'd0, by} + 13'd2;
                    phase = PH_B_LIST;
                end
                else
                begin
                    held = by;
                    phase = PH_B_BACKLO;
                end
            PH_B_LIST:
            begin
                emit_single({8'd0, by});
                pend = pend - 13'd1;
                phase = (pend != 0) ? PH_B_LIST : PH_OPCODE;
            end
            PH_B_BACKLO:
            begin
                c = {held, by};
                emit_copy(c, int'(c[5:0]) + 4);
                phase = PH_OPCODE;
            end
            PH_W_OPHI:
            begin
                c = {by, held};
                if ((c & COPY_FLAG) != 0)
                begin
                    emit_copy(c, int'(c[5:0]) + 2);
                    phase = PH_OPCODE;
                end
                else
                begin
                    pend = c[12:0];
                    byte_idx = c[13];
                    run_md = c[14];
                    phase = (!run_md && pend == 0) ? PH_OPCODE : PH_W_IDX;
                end
            end
            PH_W_IDX:
                if (byte_idx)
                    word_index({8'd0, by});
                else
                begin
                    held = by;
                    phase = PH_W_IDXHI;
                end
            default:
                word_index({by, held});
        endcase
        if (lend)
        begin
            phase = PH_OPCODE;
            pend = 13'd0;
        end
        if (pixel_queue.size() > before_n)
            pixel_queue[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------ drivers
    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.code_format = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.line_end = 1'b0;
        in_ch.palette_index = 16'd0;
        in_ch.palette_color = 24'd0;
        out_ch.ready = 1'b0;
    end

    // only indices that were written may ever be looked up below PAL_N
    function automatic logic [7:0] known_byte();
        logic [7:0] b;
        for (int t = 0; t < 64; t++)
        begin
            b = 8'($urandom_range(0, 255));
            if (pal_written[b])
                return b;
        end
        return 8'd0;
    endfunction

    // valid stays high between back to back items and drops only for a gap
    task automatic send_item(logic cmd, logic [7:0] by, logic lend,
                             logic [15:0] pi = 0, logic [23:0] col = 0);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.data_byte <= by;
        in_ch.line_end <= lend;
        in_ch.palette_index <= pi;
        in_ch.palette_color <= col;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_item(cmd, by, lend, pi, col);
    endtask

    task automatic byte_item(logic [7:0] by, logic lend = 0);
        send_item(1'b0, by, lend);
    endtask

    task automatic write_format(logic f);
        in_ch.valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.code_format <= f;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        fmt = f;
    endtask

    // ------------------------------------------------------------ tests
    task automatic test_palette_load();
        send_item(1'b1, 8'hFF, 1'b1, 16'd0, 24'hFFFFFF);
        send_item(1'b1, 8'd0, 1'b0, 16'd255, 24'h000001);
        send_item(1'b1, 8'd0, 1'b0, 16'd4095, 24'h800000);
        send_item(1'b1, 8'd0, 1'b0, 16'hFFFF, 24'h123456);   // ignored, out of range
        for (int i = 1; i < 64; i++)
            send_item(1'b1, 8'($urandom), 1'($urandom), 16'(i), 24'($urandom));
    endtask

    task automatic test_byte_directed();
        byte_item(8'd1); byte_item(8'd0);            // single-pixel run
        byte_item(8'd255); byte_item(8'd255);        // longest run
        byte_item(8'd0); byte_item(8'd0); byte_item(8'd7); byte_item(8'd9);
        byte_item(8'd0); byte_item(8'h7F);           // list, ended by line end early
        byte_item(8'd3); byte_item(8'd4, 1'b1);
        byte_item(8'd0); byte_item(8'hFF); byte_item(8'hFF);   // copy, distance 1, 67 px
        byte_item(8'd0); byte_item(8'h80); byte_item(8'h00);   // distance 512, 4 px
        byte_item(8'd5, 1'b1);                       // cut short
    endtask

    task automatic test_word_directed();
        // list of two word indices, one of them out of range
        byte_item(8'h02); byte_item(8'h00);
        byte_item(8'h10); byte_item(8'h00); byte_item(8'hFF); byte_item(8'hFF);
        // run of 0x1FFF, word index
        byte_item(8'hFF); byte_item(8'h5F); byte_item(8'h05); byte_item(8'h00);
        // empty list and empty byte run
        byte_item(8'h00); byte_item(8'h00);
        byte_item(8'h00); byte_item(8'h60); byte_item(8'h09);
        // copies: odd and even lengths, both distance extremes
        byte_item(8'hC0); byte_item(8'hFF);
        byte_item(8'h3F); byte_item(8'h80);
        // byte list of 3
        byte_item(8'h03); byte_item(8'h20); byte_item(8'h01); byte_item(8'h02); byte_item(8'h03);
    endtask

    task automatic random_byte_code();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                byte_item(8'($urandom_range(1, 255)));
                byte_item(known_byte());
            end
            3, 4, 5:
            begin
                n = $urandom_range(0, 6);
                byte_item(8'd0); byte_item(8'(n));
                for (int i = 0; i < n + 2; i++)
                    byte_item(known_byte());
            end
            6, 7, 8:
            begin
                byte_item(8'd0); byte_item(8'($urandom_range(128, 255)));
                byte_item(8'($urandom_range(0, 255)) | 8'h0F & 8'($urandom));
            end
            default:
                byte_item(8'($urandom_range(1, 255)), 1'b1);   // opcode dropped by line end
        endcase
    endtask

    // a nonzero high index byte, drawn from 16 to 255, always lands out of range
    task automatic random_word_code();
        logic [15:0] c;
        int n;
        logic ix;
        case ($urandom_range(0, 7))
            0, 1, 2:
            begin
                c = {1'b1, 15'($urandom)};
                byte_item(c[7:0]); byte_item(c[15:8]);
            end
            3, 4:
            begin
                n = $urandom_range(0, 5);
                ix = 1'($urandom);
                c = {2'b00, ix, 13'(n)};
                byte_item(c[7:0]); byte_item(c[15:8]);
                for (int i = 0; i < n; i++)
                begin
                    byte_item(known_byte());
                    if (!ix)
                        byte_item(($urandom_range(0, 15) == 0) ?
                                  8'($urandom_range(16, 255)) : 8'd0);
                end
            end
            5, 6:
            begin
                ix = 1'($urandom);
                c = {2'b01, ix, 13'($urandom_range(0, 8191))};
                byte_item(c[7:0]); byte_item(c[15:8]);
                byte_item(known_byte());
                if (!ix)
                    byte_item(($urandom_range(0, 7) == 0) ? 8'($urandom_range(16, 255)) : 8'd0);
            end
            default:
                byte_item(8'($urandom), 1'b1);
        endcase
    endtask

    task automatic test_random(int items);
        int start_n;
        start_n = 0;
        while (start_n < items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(1'b1, 8'($urandom), 1'($urandom), 16'($urandom_range(0, 4200)),
                          24'($urandom));
                start_n++;
            end
            else if (fmt)
            begin
                random_word_code();
                start_n += 3;
            end
            else
            begin
                random_byte_code();
                start_n += 3;
            end
        end
    endtask

    task automatic test_backpressure();
        stall_long = 1;
        for (int i = 0; i < 10; i++)
        begin
            byte_item(8'd0); byte_item(8'd2);
            byte_item(known_byte()); byte_item(known_byte()); byte_item(known_byte());
        end
    endtask

    // ------------------------------------------------------------ result side
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (stall_long)
            begin
                stall_long = 0;
                hold = 300;
            end
            else
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pixel_result_t got, exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.first_pixel = out_ch.first_pixel;
            got.second_pixel = out_ch.second_pixel;
            got.pair_valid = out_ch.pair_valid;
            got.repeat_count = out_ch.repeat_count;
            got.index_error = out_ch.index_error;
            got.last = out_ch.last;
            if (pixel_queue.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                exp_r = pixel_queue.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    // ------------------------------------------------------------ sequence
    initial
    begin
        for (int i = 0; i < HIST_N; i++)
            hist_mem[i] = 24'd0;
        for (int i = 0; i < PAL_N; i++)
        begin
            pal_mem[i] = 24'd0;
            pal_written[i] = 0;
        end
        hist_ptr = 0;
        phase = PH_OPCODE;
        held = 0;
        pend = 0;
        byte_idx = 0;
        run_md = 0;
        fmt = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_format(1'b0);
        test_palette_load();
        test_byte_directed();
        test_random(120);
        test_backpressure();
        write_format(1'b1);
        test_word_directed();
        test_random(120);
        write_format(1'b0);
        test_random(60);

        in_ch.valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
        if (errors == 0)
            $display("palette_lz_line_decoder_tb passed");
        else
            $display("palette_lz_line_decoder_tb failed");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("palette_lz_line_decoder_tb failed");
        $finish;
    end
endmodule
